@@ hw/rtl/spq_pkg.sv @@
// Shared types, constants and codes for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue_top and the bench.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted chain: holds one value/priority pair.
// Depends on spq_pkg (t_entry, t_cmd).
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire  i_clk,
    input  t_cmd i_cmd,
    input  wire  i_occupied,   // this slot is below the entry count
    input  t_entry i_left,     // entry of the slot nearer the head
    input  wire  i_left_wants, // slot nearer the head also moves on enqueue
    input  t_entry i_right,    // entry of the slot nearer the tail
    output t_entry o_entry,
    output logic o_wants
);

    t_entry r_entry;
    t_entry n_entry;

    // a slot moves on enqueue if it is free or holds a strictly lower priority
    assign o_wants = !i_occupied || (r_entry.prio < i_cmd.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq && o_wants) begin
            n_entry = i_left_wants ? i_left : i_cmd.item;
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: stream ports, entry count, result register.
// Depends on spq_pkg and spq_cell.
`default_nettype none

// Sorted priority queue of CAPACITY value/priority pairs, highest priority at the
// head, equal priorities served in arrival order. Each input item is an enqueue
// (tuser 0) or a dequeue (tuser 1); each gives exactly one result item with a
// status, the dequeued value (0 when none) and the occupancy after the item.
// The block takes one item per clock cycle while results are drained, and its result
// appears in the output register on the next cycle. That rate is set by the chain of
// slot cells: every cell compares its priority with the new one in parallel, and
// all cells shift toward the tail or the head together. The input is ready whenever
// the output register is empty or being drained, so the input stalls while a result
// waits and moves again in the cycle that result is taken. An enqueue at capacity is
// dropped with status full; a dequeue on an empty queue reports status empty.
// Reset empties the queue; slot contents are not cleared.

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input items
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,  // [31:0] item_value, [47:32] item_priority
    input  wire                   i_s_axis_tuser,  // [0] command
    // result items
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [31:0] head_value, [36:32] occupancy
    output logic [STATUS_W-1:0]   o_m_axis_tuser   // [1:0] status
);

    logic accept;
    logic full;
    logic empty;
    t_cmd cmd;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [STATUS_W-1:0]       n_status;
    logic signed [VALUE_W-1:0] r_head;
    logic signed [VALUE_W-1:0] n_head;
    logic [OCC_W-1:0]          r_occ;

    t_entry               w_entry [CAPACITY];
    logic [CAPACITY-1:0]  w_wants;

    // accept while the result register is free or drains this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    assign cmd.item.value = i_s_axis_tdata[VALUE_W-1:0];
    assign cmd.item.prio  = i_s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];
    assign cmd.enq = accept && (i_s_axis_tuser == CMD_ENQ) && !full;
    assign cmd.deq = accept && (i_s_axis_tuser == CMD_DEQ) && !empty;

    // slot chain: cell 0 is the head
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_wants;

            if (gi == 0) begin : g_head
                assign left_entry = cmd.item;
                assign left_wants = 1'b0;
            end else begin : g_mid
                assign left_entry = w_entry[gi-1];
                assign left_wants = w_wants[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                // the tail slot becomes free on dequeue; its contents do not matter
                assign right_entry = cmd.item;
            end else begin : g_inner
                assign right_entry = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occupied   (CNT_W'(gi) < r_count),
                .i_left       (left_entry),
                .i_left_wants (left_wants),
                .i_right      (right_entry),
                .o_entry      (w_entry[gi]),
                .o_wants      (w_wants[gi])
            );
        end
    endgenerate

    // result and next count
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_head   = '0;
        if (i_s_axis_tuser == CMD_ENQ) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                n_head  = w_entry[0].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the payload while a result waits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_head   <= n_head;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - OCC_W){1'b0}}, r_occ, r_head};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_axis_tuser == CMD_ENQ) && full
        |=> (r_status == ST_FULL) && $stable(r_count))
        else $error("enqueue at capacity changed the queue");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_s_axis_tuser == CMD_DEQ) && empty
        |=> (r_status == ST_EMPTY) && (r_count == '0))
        else $error("dequeue on empty queue changed the queue");

    a_zero_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != ST_DONE) |-> (r_head == '0))
        else $error("failed item returned a nonzero value");
`endif

endmodule

`default_nettype wire

@@ dv/tb_sorted_priority_queue_top.sv @@
// Self-checking bench for sorted_priority_queue_top: a shadow sorted list tracks
// every accepted item and each result item is compared field by field.
// Depends on spq_pkg and the RTL of the sorted priority queue.

module tb_sorted_priority_queue_top;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_OPS    = 1600;
    localparam int SETTLE_CYCLES = 10;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_COMB   = 3;

    // mix of commands in one random segment
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_EVEN    = 2;
    localparam int MIX_NEARTOP = 3;

    typedef struct {
        logic                cmd;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
        bit                  drain_first;  // hold this item until nothing is outstanding
    } t_op;

    typedef struct {
        logic                cmd;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  head_value;
        logic [OCC_W-1:0]    occupancy;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;  // [31:0] item_value, [47:32] item_priority
    logic                  i_s_axis_tuser = 1'b0;  // [0] command
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;  // [31:0] head_value, [36:32] occupancy
    logic [STATUS_W-1:0]   o_m_axis_tuser;  // [1:0] status

    sorted_priority_queue_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the sorted list, head in slot 0.
    logic [VALUE_W-1:0] shadow_val [CAPACITY];
    logic [PRIO_W-1:0]  shadow_pri [CAPACITY];
    int                 shadow_count = 0;

    t_op      ops_to_send [$];
    t_outcome outcomes_due [$];

    int n_open = 0;  // items accepted minus results accepted, updated with NBA
    int cycle_count = 0;
    int fails = 0;
    int n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0;

    // Apply one command to the shadow list and return the result it must give.
    function automatic t_outcome apply_pq_op(logic cmd, logic [VALUE_W-1:0] v,
                                             logic [PRIO_W-1:0] p);
        int pos;
        t_outcome r;
        r.cmd = cmd;
        r.status = ST_DONE;
        r.head_value = '0;
        if (cmd == CMD_ENQ) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // land behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_pri[pos] >= p) pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_val[k] = shadow_val[k-1];
                    shadow_pri[k] = shadow_pri[k-1];
                end
                shadow_val[pos] = v;
                shadow_pri[pos] = p;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.head_value = shadow_val[0];
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_val[k-1] = shadow_val[k];
                    shadow_pri[k-1] = shadow_pri[k];
                end
                shadow_count--;
            end
        end
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic add_op(logic cmd, logic [VALUE_W-1:0] v, logic [PRIO_W-1:0] p,
                          bit drain);
        t_op op;
        op.cmd = cmd;
        op.value = v;
        op.prio = p;
        op.drain_first = drain;
        ops_to_send.push_back(op);
    endtask

    // Priorities: clustered values provoke ties, the rest spans the full range.
    function automatic logic [PRIO_W-1:0] pick_prio();
        logic [PRIO_W-1:0] p;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: p = '0;
                    1: p = '1;
                    2: p = 16'h8000;
                    3: p = 16'h7fff;
                    default: p = 16'd1;
                endcase
            end
            1: p = PRIO_W'($urandom_range(0, 7));
            default: p = PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = '1;
            3: v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- sender
    int gap_left = 0;
    int burst_left = 8;
    t_op next_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (ops_to_send.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (ops_to_send[0].drain_first &&
                         (i_s_axis_tvalid || n_open != 0)) begin
                // hold off until the block has handed back every result
                i_s_axis_tvalid <= 1'b0;
            end else begin
                next_op = ops_to_send.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {next_op.prio, next_op.value};
                i_s_axis_tuser  <= next_op.cmd;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // -------------------------------------------------------------- receiver
    int rx_mode = RX_OPEN;
    int rx_left = 40;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_COMB);
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_axis_tready <= (cycle_count[2:0] != 3'd5 &&
                                           cycle_count[2:0] != 3'd6);
        endcase
    end

    // --------------------------------------------------------------- monitor
    t_outcome want;
    bit in_fire, out_fire;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            in_fire  = i_s_axis_tvalid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && i_m_axis_tready;
            // check first: a result never belongs to an item accepted at the same edge
            if (out_fire) begin
                if (outcomes_due.size() == 0) begin
                    $error("result item with no item outstanding: tdata %h tuser %h",
                           o_m_axis_tdata, o_m_axis_tuser);
                    fails++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (o_m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                        fails++;
                    end
                    if (o_m_axis_tdata[31:0] !== want.head_value) begin
                        $error("head_value: expected %0d, got %0d",
                               $signed(want.head_value), $signed(o_m_axis_tdata[31:0]));
                        fails++;
                    end
                    if (o_m_axis_tdata[36:32] !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, o_m_axis_tdata[36:32]);
                        fails++;
                    end
                    if (want.cmd == CMD_ENQ) n_enq++;
                    else n_deq++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_EMPTY) n_empty++;
                end
            end
            if (in_fire) begin
                outcomes_due.push_back(apply_pq_op(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                                   i_s_axis_tdata[47:32]));
            end
            n_open <= n_open + int'(in_fire) - int'(out_fire);
        end
    end

    // --------------------------------------------------------------- timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, outcomes_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // -------------------------------------------------------------- stimulus
    int made;
    int seg_len;
    int mix;
    int enq_pct;

    initial begin
        // directed: empty dequeue, extremes, ties, head order
        add_op(CMD_DEQ, '1, '1, 0);
        add_op(CMD_ENQ, 32'h7fff_ffff, 16'hffff, 0);
        add_op(CMD_ENQ, 32'h8000_0000, 16'h0000, 0);
        add_op(CMD_ENQ, 32'hffff_ffff, 16'h8000, 0);
        add_op(CMD_ENQ, 32'h0000_0000, 16'h8000, 0);
        add_op(CMD_ENQ, 32'h0000_0001, 16'hffff, 0);
        add_op(CMD_DEQ, '0, '0, 0);
        add_op(CMD_DEQ, '0, '0, 0);
        // fill to capacity, then one enqueue that must be refused
        for (int i = 0; i < CAPACITY - 3; i++) add_op(CMD_ENQ, pick_value(), pick_prio(), 0);
        add_op(CMD_ENQ, 32'h1234_5678, 16'hffff, 0);
        add_op(CMD_DEQ, '0, '0, 0);
        add_op(CMD_DEQ, '1, '1, 0);

        // random: segments biased toward filling, draining or hovering near full
        made = 0;
        while (made < RANDOM_OPS) begin
            mix = $urandom_range(MIX_FILL, MIX_NEARTOP);
            case (mix)
                MIX_FILL:  enq_pct = 85;
                MIX_DRAIN: enq_pct = 15;
                MIX_EVEN:  enq_pct = 50;
                default:   enq_pct = 60;
            endcase
            seg_len = $urandom_range(20, 80);
            for (int i = 0; i < seg_len; i++) begin
                // pause for a full drain at the first random item and now and then
                add_op(($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_DEQ,
                       pick_value(), pick_prio(),
                       (i == 0) && (made == 0 || $urandom_range(0, 4) == 0));
                made++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every item to go out and every result to come back;
        // sample between edges so sender and monitor updates have settled
        @(posedge i_clk);
        @(negedge i_clk);
        while (ops_to_send.size() != 0 || i_s_axis_tvalid || n_open != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (outcomes_due.size() != 0) begin
            $error("%0d results never arrived", outcomes_due.size());
            fails++;
        end
        $display("covered %0d enqueues (%0d refused at full) and %0d dequeues (%0d on empty)",
                 n_enq, n_full, n_deq, n_empty);
        $display("in %0d cycles with random sender gaps and receiver stalls", cycle_count);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
